### hdl/lfdl_pkg.sv
package lfdl_pkg;

  localparam int LFDL_TABLE_DEPTH  = 65536;
  localparam int LFDL_MODULUS_BITS = 31;
  localparam int LFDL_EXPO_BITS    = 16;
  localparam int LFDL_INDEX_BITS   = 32;
  localparam int LFDL_SQRT_BITS    = 16;
  localparam int LFDL_ROOT_BITS    = 17;
  localparam int LFDL_IK_BITS      = 33;
  localparam int LFDL_POW_BITS     = 32;
  localparam int LFDL_HASH_SHIFT   = 7;
  localparam logic [31:0] LFDL_HASH_MULT = 32'd2654435761;
  localparam int LFDL_RAM_WIDTH    = 1 + LFDL_MODULUS_BITS + LFDL_EXPO_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_MUL_WAIT,
    S_DECIDE,
    S_COMB,
    S_POW_CHK,
    S_POW_ACC,
    S_POW_SQR,
    S_SQRT,
    S_CLEAR,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DONE
  } lfdl_state_t;

  typedef enum logic [3:0] {
    PH_RED_A,
    PH_RED_B,
    PH_RED_X,
    PH_RED_T,
    PH_INV_B,
    PH_LIN,
    PH_INV_A1,
    PH_C,
    PH_INV_D,
    PH_GOAL,
    PH_BABY,
    PH_STEP,
    PH_GIANT
  } lfdl_phase_t;

endpackage

### hdl/lfdl_if.sv
interface lfdl_in_if import lfdl_pkg::*; #(
  parameter int MODULUS_BITS = LFDL_MODULUS_BITS
);
  logic                    valid;
  logic                    ready;
  logic [MODULUS_BITS-1:0] modulus;
  logic [MODULUS_BITS-1:0] multiplier;
  logic [MODULUS_BITS-1:0] increment;
  logic [MODULUS_BITS-1:0] start_value;
  logic [MODULUS_BITS-1:0] target_value;

  modport source (output valid, modulus, multiplier, increment, start_value, target_value,
                  input ready);
  modport sink (input valid, modulus, multiplier, increment, start_value, target_value,
                output ready);
endinterface

interface lfdl_out_if import lfdl_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [LFDL_INDEX_BITS-1:0] first_index;

  modport source (output valid, found, first_index, input ready);
  modport sink (input valid, found, first_index, output ready);
endinterface

### hdl/lcg_first_hit_discrete_log_core.sv
// Items with modulus >= 2 first reduce their four inputs by modular multiplies; inverse cases add a
// Fermat exponentiation of up to 2*MODULUS_BITS modular multiplies on the bit-serial multiplier.
// General case: a TABLE_DEPTH-entry table clear, then baby steps and giant steps up to k each,
// k = floor(sqrt(modulus))+1, with a hash table probe loop for every step.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset clears control state; the table is swept clear by each item that uses it.
module lcg_first_hit_discrete_log_core import lfdl_pkg::*; #(
  parameter int TABLE_DEPTH  = LFDL_TABLE_DEPTH,
  parameter int MODULUS_BITS = LFDL_MODULUS_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  lfdl_in_if.sink     in_chan,
  lfdl_out_if.source  out_chan
);

  // TABLE_DEPTH must be a power of two
  localparam int MB = MODULUS_BITS;
  localparam int AB = $clog2(TABLE_DEPTH);
  localparam int EB = LFDL_EXPO_BITS;
  localparam int MW = 1 + MB + EB;
  localparam int HB = LFDL_HASH_SHIFT + AB;
  localparam int RW = LFDL_ROOT_BITS;
  localparam int SW = LFDL_SQRT_BITS;
  localparam int KW = LFDL_IK_BITS;
  localparam int PW = LFDL_POW_BITS;
  localparam int IW = LFDL_INDEX_BITS;
  localparam logic [31:0] HASH_MULT_W = LFDL_HASH_MULT;
  localparam logic [HB-1:0] HMUL = HASH_MULT_W[HB-1:0];

  lfdl_state_t state_r, state_nxt;
  lfdl_phase_t phase_r, phase_nxt;

  logic [MB-1:0]   p_r, p_nxt;
  logic [MB-1:0]   a_r, a_nxt;
  logic [MB-1:0]   b_r, b_nxt;
  logic [MB-1:0]   x1_r, x1_nxt;
  logic [MB-1:0]   t_r, t_nxt;
  logic [MB-1:0]   inv_r, inv_nxt;
  logic [MB-1:0]   c_r, c_nxt;
  logic [MB-1:0]   aux_r, aux_nxt;
  logic [MB-1:0]   val_r, val_nxt;
  logic [MB-1:0]   step_r, step_nxt;
  logic [RW-1:0]   k_r, k_nxt;
  logic [RW-1:0]   i_r, i_nxt;
  logic [KW-1:0]   ik_r, ik_nxt;
  logic [MB-1:0]   pacc_r, pacc_nxt;
  logic [MB-1:0]   pbase_r, pbase_nxt;
  logic [PW-1:0]   pexp_r, pexp_nxt;
  logic [SW-1:0]   sq_res_r, sq_res_nxt;
  logic [3:0]      sq_bit_r, sq_bit_nxt;
  logic [AB-1:0]   clr_r, clr_nxt;
  logic [AB-1:0]   slot_r, slot_nxt;
  logic [AB:0]     tries_r, tries_nxt;
  logic            res_found_r, res_found_nxt;
  logic [IW-1:0]   res_idx_r, res_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_found_r, out_found_nxt;
  logic [IW-1:0]   out_idx_r, out_idx_nxt;

  logic            mul_start;
  logic            mul_done;
  logic [MB-1:0]   mul_x;
  logic [MB-1:0]   mul_y;
  logic [MB-1:0]   mul_prod;

  logic            ram_we;
  logic [AB-1:0]   ram_waddr;
  logic [MW-1:0]   ram_wdata;
  logic [MW-1:0]   ram_rdata;
  logic            rd_valid;
  logic [MB-1:0]   rd_key;
  logic [EB-1:0]   rd_expo;

  logic [HB+MB-1:0] key_wide;
  logic [HB-1:0]    key_ext;
  logic [2*HB-1:0]  hprod;
  logic [AB-1:0]    hash_slot;

  logic [SW-1:0]   sq_cand;
  logic [31:0]     sq_sq;
  logic [SW-1:0]   sq_pick;
  logic [MB:0]     dsum;
  logic [MB:0]     hsum;
  logic [MB-1:0]   d_val;
  logic [MB-1:0]   h_val;
  logic [MB:0]     diff_w;
  logic [AB:0]     tries_inc;
  logic            probe_last;
  logic [KW:0]     hit_idx;

  lfdl_modmul #(.MODULUS_BITS(MB)) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (p_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  lfdl_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign rd_valid = ram_rdata[MW-1];
  assign rd_key   = ram_rdata[MW-2:EB];
  assign rd_expo  = ram_rdata[EB-1:0];

  assign key_wide  = {{HB{1'b0}}, val_r};
  assign key_ext   = key_wide[HB-1:0];
  assign hprod     = {{HB{1'b0}}, key_ext} * {{HB{1'b0}}, HMUL};
  assign hash_slot = hprod[HB-1:LFDL_HASH_SHIFT];

  assign sq_cand = sq_res_r | (SW'(1) << sq_bit_r);
  assign sq_sq   = 32'(sq_cand) * 32'(sq_cand);
  assign sq_pick = (sq_sq <= 32'(p_r)) ? sq_cand : sq_res_r;

  assign dsum  = {1'b0, x1_r} + {1'b0, c_r};
  assign hsum  = {1'b0, t_r} + {1'b0, c_r};
  assign d_val = (dsum >= {1'b0, p_r}) ? MB'(dsum - {1'b0, p_r}) : dsum[MB-1:0];
  assign h_val = (hsum >= {1'b0, p_r}) ? MB'(hsum - {1'b0, p_r}) : hsum[MB-1:0];
  assign diff_w = (t_r >= x1_r) ? ({1'b0, t_r} - {1'b0, x1_r})
                                : ({1'b0, t_r} + {1'b0, p_r} - {1'b0, x1_r});

  assign tries_inc  = tries_r + (AB+1)'(1);
  assign probe_last = (tries_inc == (AB+1)'(TABLE_DEPTH));
  assign hit_idx    = {1'b0, ik_r} - (KW+1)'(rd_expo) + (KW+1)'(1);

  always_comb begin
    mul_x = pbase_r;
    mul_y = pbase_r;
    if (state_r == S_MUL) begin
      case (phase_r)
        PH_RED_A:  begin mul_x = a_r;   mul_y = MB'(1); end
        PH_RED_B:  begin mul_x = b_r;   mul_y = MB'(1); end
        PH_RED_X:  begin mul_x = x1_r;  mul_y = MB'(1); end
        PH_RED_T:  begin mul_x = t_r;   mul_y = MB'(1); end
        PH_LIN:    begin mul_x = aux_r; mul_y = inv_r; end
        PH_C:      begin mul_x = b_r;   mul_y = inv_r; end
        PH_GOAL:   begin mul_x = aux_r; mul_y = inv_r; end
        PH_GIANT:  begin mul_x = val_r; mul_y = step_r; end
        default:   begin mul_x = val_r; mul_y = a_r; end
      endcase
    end else if (state_r == S_POW_CHK && pexp_r[0]) begin
      mul_x = pacc_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    p_nxt         = p_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    x1_nxt        = x1_r;
    t_nxt         = t_r;
    inv_nxt       = inv_r;
    c_nxt         = c_r;
    aux_nxt       = aux_r;
    val_nxt       = val_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    ik_nxt        = ik_r;
    pacc_nxt      = pacc_r;
    pbase_nxt     = pbase_r;
    pexp_nxt      = pexp_r;
    sq_res_nxt    = sq_res_r;
    sq_bit_nxt    = sq_bit_r;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    tries_nxt     = tries_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    mul_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = {1'b1, val_r, i_r[EB-1:0]};
    in_chan.ready = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          p_nxt         = in_chan.modulus;
          a_nxt         = in_chan.multiplier;
          b_nxt         = in_chan.increment;
          x1_nxt        = in_chan.start_value;
          t_nxt         = in_chan.target_value;
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          if (in_chan.modulus < MB'(2)) begin
            state_nxt = S_DONE;
          end else begin
            phase_nxt = PH_RED_A;
            state_nxt = S_MUL;
          end
        end
      end

      S_MUL: begin
        mul_start = 1'b1;
        state_nxt = S_MUL_WAIT;
      end

      S_MUL_WAIT: begin
        if (mul_done) begin
          case (phase_r)
            PH_RED_A: begin
              a_nxt = mul_prod; phase_nxt = PH_RED_B; state_nxt = S_MUL;
            end
            PH_RED_B: begin
              b_nxt = mul_prod; phase_nxt = PH_RED_X; state_nxt = S_MUL;
            end
            PH_RED_X: begin
              x1_nxt = mul_prod; phase_nxt = PH_RED_T; state_nxt = S_MUL;
            end
            PH_RED_T: begin
              t_nxt = mul_prod; state_nxt = S_DECIDE;
            end
            PH_LIN: begin
              res_found_nxt = 1'b1;
              res_idx_nxt   = IW'(mul_prod) + IW'(1);
              state_nxt     = S_DONE;
            end
            PH_C: begin
              c_nxt = mul_prod; state_nxt = S_COMB;
            end
            PH_GOAL: begin
              val_nxt    = mul_prod;
              sq_res_nxt = '0;
              sq_bit_nxt = 4'(SW - 1);
              state_nxt  = S_SQRT;
            end
            PH_BABY: begin
              val_nxt   = mul_prod;
              i_nxt     = i_r + RW'(1);
              state_nxt = S_HASH;
            end
            PH_GIANT: begin
              val_nxt   = mul_prod;
              i_nxt     = i_r + RW'(1);
              ik_nxt    = ik_r + KW'(k_r);
              state_nxt = S_HASH;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_DECIDE: begin
        pacc_nxt = MB'(1);
        pexp_nxt = PW'(p_r) - PW'(2);
        if (x1_r == t_r) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = IW'(1);
          state_nxt     = S_DONE;
        end else if (a_r == '0) begin
          if (b_r == t_r) begin
            res_found_nxt = 1'b1;
            res_idx_nxt   = IW'(2);
          end
          state_nxt = S_DONE;
        end else if (a_r == MB'(1)) begin
          if (b_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            aux_nxt   = diff_w[MB-1:0];
            pbase_nxt = b_r;
            phase_nxt = PH_INV_B;
            state_nxt = S_POW_CHK;
          end
        end else begin
          pbase_nxt = a_r - MB'(1);
          phase_nxt = PH_INV_A1;
          state_nxt = S_POW_CHK;
        end
      end

      S_COMB: begin
        if (d_val == '0) begin
          state_nxt = S_DONE;
        end else begin
          aux_nxt   = h_val;
          pacc_nxt  = MB'(1);
          pbase_nxt = d_val;
          pexp_nxt  = PW'(p_r) - PW'(2);
          phase_nxt = PH_INV_D;
          state_nxt = S_POW_CHK;
        end
      end

      S_POW_CHK: begin
        if (pexp_r == '0) begin
          case (phase_r)
            PH_INV_B: begin
              inv_nxt = pacc_r; phase_nxt = PH_LIN; state_nxt = S_MUL;
            end
            PH_INV_A1: begin
              inv_nxt = pacc_r; phase_nxt = PH_C; state_nxt = S_MUL;
            end
            PH_INV_D: begin
              inv_nxt = pacc_r; phase_nxt = PH_GOAL; state_nxt = S_MUL;
            end
            PH_STEP: begin
              step_nxt  = pacc_r;
              val_nxt   = pacc_r;
              i_nxt     = RW'(1);
              ik_nxt    = KW'(k_r);
              phase_nxt = PH_GIANT;
              state_nxt = S_HASH;
            end
            default: state_nxt = S_DONE;
          endcase
        end else begin
          mul_start = 1'b1;
          state_nxt = pexp_r[0] ? S_POW_ACC : S_POW_SQR;
        end
      end

      S_POW_ACC: begin
        if (mul_done) begin
          pacc_nxt  = mul_prod;
          mul_start = 1'b1;
          state_nxt = S_POW_SQR;
        end
      end

      S_POW_SQR: begin
        if (mul_done) begin
          pbase_nxt = mul_prod;
          pexp_nxt  = pexp_r >> 1;
          state_nxt = S_POW_CHK;
        end
      end

      S_SQRT: begin
        sq_res_nxt = sq_pick;
        if (sq_bit_r == '0) begin
          k_nxt     = RW'(sq_pick) + RW'(1);
          clr_nxt   = '0;
          state_nxt = S_CLEAR;
        end else begin
          sq_bit_nxt = sq_bit_r - 4'(1);
        end
      end

      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AB'(1);
        if (&clr_r) begin
          i_nxt     = '0;
          phase_nxt = PH_BABY;
          state_nxt = S_HASH;
        end
      end

      S_HASH: begin
        slot_nxt  = hash_slot;
        tries_nxt = '0;
        state_nxt = S_PROBE_RD;
      end

      S_PROBE_RD: begin
        state_nxt = S_PROBE_CHK;
      end

      S_PROBE_CHK: begin
        if (phase_r == PH_BABY) begin
          if (!rd_valid || rd_key == val_r || probe_last) begin
            ram_we = !rd_valid || rd_key == val_r;
            if (i_r + RW'(1) == k_r) begin
              pacc_nxt  = MB'(1);
              pbase_nxt = a_r;
              pexp_nxt  = PW'(k_r);
              phase_nxt = PH_STEP;
              state_nxt = S_POW_CHK;
            end else begin
              state_nxt = S_MUL;
            end
          end else begin
            slot_nxt  = slot_r + AB'(1);
            tries_nxt = tries_inc;
            state_nxt = S_PROBE_RD;
          end
        end else begin
          if (rd_valid && rd_key == val_r) begin
            res_found_nxt = 1'b1;
            res_idx_nxt   = hit_idx[IW-1:0];
            state_nxt     = S_DONE;
          end else if (!rd_valid || probe_last) begin
            state_nxt = (i_r == k_r) ? S_DONE : S_MUL;
          end else begin
            slot_nxt  = slot_r + AB'(1);
            tries_nxt = tries_inc;
            state_nxt = S_PROBE_RD;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_RED_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    x1_r        <= x1_nxt;
    t_r         <= t_nxt;
    inv_r       <= inv_nxt;
    c_r         <= c_nxt;
    aux_r       <= aux_nxt;
    val_r       <= val_nxt;
    step_r      <= step_nxt;
    k_r         <= k_nxt;
    i_r         <= i_nxt;
    ik_r        <= ik_nxt;
    pacc_r      <= pacc_nxt;
    pbase_r     <= pbase_nxt;
    pexp_r      <= pexp_nxt;
    sq_res_r    <= sq_res_nxt;
    sq_bit_r    <= sq_bit_nxt;
    clr_r       <= clr_nxt;
    slot_r      <= slot_nxt;
    tries_r     <= tries_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.first_index = out_idx_r;

endmodule

### hdl/lfdl_ram.sv
module lfdl_ram import lfdl_pkg::*; #(
  parameter int WIDTH = LFDL_RAM_WIDTH,
  parameter int DEPTH = LFDL_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/lfdl_modmul.sv
module lfdl_modmul import lfdl_pkg::*; #(
  parameter int MODULUS_BITS = LFDL_MODULUS_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [MODULUS_BITS-1:0] x,
  input  logic [MODULUS_BITS-1:0] y,
  input  logic [MODULUS_BITS-1:0] m,
  output logic                    done,
  output logic [MODULUS_BITS-1:0] prod
);

  localparam int MB = MODULUS_BITS;
  localparam int CW = $clog2(MB + 1);

  logic [MB-1:0] acc_r;
  logic [MB-1:0] xs_r;
  logic [MB-1:0] y_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [MB+1:0] sum;
  logic [MB+1:0] m1;
  logic [MB+1:0] m2;
  logic [MB+1:0] red;

  always_comb begin
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (xs_r[MB-1] ? {2'b00, y_r} : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(MB);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      xs_r  <= x;
      y_r   <= y;
    end else if (run_r) begin
      acc_r <= red[MB-1:0];
      xs_r  <= {xs_r[MB-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
